### sv/fmb_pkg.sv
// Package: shared types, constants and Booth digit helper for the float multiplier.
package fmb_pkg;

   localparam int SigWidth   = 24;
   localparam int ProdWidth  = 48;
   localparam int NumDigits  = 12;
   localparam int ExpBias    = 127;
   localparam int ExpMax     = 255;
   localparam logic [7:0]  ExpInf  = 8'hFF;

   typedef struct packed {
      logic [31:0] operand_a;
      logic [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [31:0] product;
      logic        overflow_flag;
      logic        underflow_flag;
   } rsp_type;

   // Operand side-band data that travels along the cell chain.
   typedef struct packed {
      logic       valid;
      logic       sign;
      logic       zero;
      logic [9:0] exp_sum;
   } side_type;

   // Partial product for one radix-4 digit selected by a bit triplet.
   function automatic logic [ProdWidth-1:0] booth_term(
      input logic [2:0]          trip,
      input logic [SigWidth-1:0] x
   );
      logic [ProdWidth-1:0] xe;
      logic [ProdWidth-1:0] term;
      xe = {{(ProdWidth-SigWidth){1'b0}}, x};
      case (trip)
         3'd1, 3'd2: term = xe;
         3'd3:       term = xe << 1;
         3'd4:       term = '0 - (xe << 1);
         3'd5, 3'd6: term = '0 - xe;
         default:    term = '0;
      endcase
      return term;
   endfunction

endpackage

### sv/fmb_cell.sv
// Cell: adds one Booth digit into the running product and hands it to the next cell.
module fmb_cell import fmb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [3:0]           digit_idx,
   input  side_type             side_i,
   input  logic [SigWidth-1:0]  x_i,
   input  logic [SigWidth:0]    ycat_i,
   input  logic [ProdWidth-1:0] acc_i,
   output side_type             side_o,
   output logic [SigWidth-1:0]  x_o,
   output logic [SigWidth:0]    ycat_o,
   output logic [ProdWidth-1:0] acc_o
);

   logic [2:0]           trip;
   logic [ProdWidth-1:0] acc_in;
   logic [ProdWidth-1:0] acc_ff;
   logic [SigWidth-1:0]  x_ff;
   logic [SigWidth:0]    ycat_ff;
   side_type             side_in;
   side_type             side_ff;

   assign trip    = ycat_i[{digit_idx, 1'b0} +: 3];
   assign acc_in  = acc_i + (booth_term(trip, x_i) << {digit_idx, 1'b0});
   assign side_in = side_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (advance) begin
         side_ff <= side_in;
         acc_ff  <= acc_in;
         x_ff    <= x_i;
         ycat_ff <= ycat_i;
      end
   end

   assign side_o = side_ff;
   assign x_o    = x_ff;
   assign ycat_o = ycat_ff;
   assign acc_o  = acc_ff;

endmodule

### sv/fmb_round.sv
// Final stage: correction add, normalization, exponent range check, output register.
module fmb_round import fmb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  side_type             side_i,
   input  logic [SigWidth-1:0]  x_i,
   input  logic [ProdWidth-1:0] acc_i,
   output logic                 valid_o,
   output rsp_type              rsp_o
);

   logic [ProdWidth-1:0] p;
   logic                 norm;
   logic [22:0]          frac;
   logic signed [10:0]   e;
   rsp_type              rsp_in;
   rsp_type              rsp_ff;
   logic                 valid_ff;

   always_comb begin
      p    = acc_i + ({{(ProdWidth-SigWidth){1'b0}}, x_i} << SigWidth);
      norm = p[ProdWidth-1];
      frac = norm ? p[46:24] : p[45:23];
      e    = $signed({1'b0, side_i.exp_sum}) - 11'(ExpBias) + {10'd0, norm};
      rsp_in = '0;
      rsp_in.product[31] = side_i.sign;
      if (!side_i.zero) begin
         if (e >= 11'(ExpMax)) begin
            rsp_in.product[30:23] = ExpInf;
            rsp_in.overflow_flag  = 1'b1;
         end else if (e <= 11'sd0) begin
            rsp_in.underflow_flag = 1'b1;
         end else begin
            rsp_in.product[30:0] = {e[7:0], frac};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= side_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign valid_o = valid_ff;
   assign rsp_o   = rsp_ff;

endmodule

### sv/float_multiply_booth.sv
// Top level: IEEE-754 single-precision multiplier built from a chain of Booth cells.
// Usage:
//   Present operand_a/operand_b on req_payload with req_valid; a transaction is
//   taken when req_valid and req_ready are both high. Each product leaves on
//   rsp_payload with rsp_valid and is taken when rsp_ready is high.
//   The pipeline is twelve Booth cells, one per radix-4 digit, and one
//   stage for the correction add, normalization and exponent check.
//   Throughput is one transaction per cycle while the output is not stalled;
//   each cell holds one operand pair and passes it to its neighbor on advance.
//   The whole chain advances only when the output register is empty or being
//   taken, so a stalled receiver holds every stage and deasserts req_ready.
//   Flags: overflow_flag marks a result forced to infinity, underflow_flag one
//   flushed to zero. A zero exponent field counts as zero.
//   Reset clears all valid bits; no transaction is in flight afterward.
module float_multiply_booth import fmb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic                 advance;
   side_type             side   [NumDigits+1];
   logic [SigWidth-1:0]  xs     [NumDigits+1];
   logic [SigWidth:0]    ycats  [NumDigits+1];
   logic [ProdWidth-1:0] accs   [NumDigits+1];

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   assign side[0].valid   = req_valid;
   assign side[0].sign    = req_payload.operand_a[31] ^ req_payload.operand_b[31];
   assign side[0].zero    = (req_payload.operand_a[30:23] == 8'd0) ||
                            (req_payload.operand_b[30:23] == 8'd0);
   assign side[0].exp_sum = {2'b00, req_payload.operand_a[30:23]} +
                            {2'b00, req_payload.operand_b[30:23]};
   assign xs[0]    = {1'b1, req_payload.operand_a[22:0]};
   assign ycats[0] = {1'b1, req_payload.operand_b[22:0], 1'b0};
   assign accs[0]  = '0;

   for (genvar g = 0; g < NumDigits; g++) begin : g_cell
      fmb_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .digit_idx (4'(g)),
         .side_i    (side[g]),
         .x_i       (xs[g]),
         .ycat_i    (ycats[g]),
         .acc_i     (accs[g]),
         .side_o    (side[g+1]),
         .x_o       (xs[g+1]),
         .ycat_o    (ycats[g+1]),
         .acc_o     (accs[g+1])
      );
   end

   fmb_round u_round (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .side_i  (side[NumDigits]),
      .x_i     (xs[NumDigits]),
      .acc_i   (accs[NumDigits]),
      .valid_o (rsp_valid),
      .rsp_o   (rsp_payload)
   );

endmodule
